// ===== design/rwlm_pkg.sv =====
`timescale 1ns / 1ps

package rwlm_pkg;

  // sizing
  localparam int MAX_READERS = 8;
  localparam int ID_BITS     = 8;
  localparam int REQ_ID_W    = 8;
  localparam int CNT_W       = $clog2(MAX_READERS + 1);
  localparam int IDX_W       = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  // request kinds
  localparam logic [1:0] REQ_START_READ  = 2'd0;
  localparam logic [1:0] REQ_STOP_READ   = 2'd1;
  localparam logic [1:0] REQ_START_WRITE = 2'd2;
  localparam logic [1:0] REQ_STOP_WRITE  = 2'd3;

  // status codes
  localparam logic [3:0] ST_READ_GRANTED   = 4'd0;
  localparam logic [3:0] ST_ALREADY_READ   = 4'd1;
  localparam logic [3:0] ST_WRITER_ACTIVE  = 4'd2;
  localparam logic [3:0] ST_READ_STOPPED   = 4'd3;
  localparam logic [3:0] ST_NOT_READING    = 4'd4;
  localparam logic [3:0] ST_NO_READERS     = 4'd5;
  localparam logic [3:0] ST_WRITE_GRANTED  = 4'd6;
  localparam logic [3:0] ST_WRITER_BUSY    = 4'd7;
  localparam logic [3:0] ST_READERS_ACTIVE = 4'd8;
  localparam logic [3:0] ST_WRITE_STOPPED  = 4'd9;
  localparam logic [3:0] ST_NOT_OWNER      = 4'd10;
  localparam logic [3:0] ST_TABLE_FULL     = 4'd11;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic shift;
  } rwlm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_shift;
    logic shift_done;
  } rwlm_stat_t;

  // port id to internal id width (truncate or zero-extend)
  function automatic id_t to_id(input logic [REQ_ID_W-1:0] raw);
    id_t v;
    v = '0;
    for (int i = 0; i < ID_BITS; i++) begin
      if (i < REQ_ID_W) begin
        v[i] = raw[i];
      end
    end
    return v;
  endfunction

  // reader count to the 4-bit result field
  function automatic logic [3:0] cnt_to_out(input cnt_t c);
    logic [3:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CNT_W) begin
        v[i] = c[i];
      end
    end
    return v;
  endfunction

endpackage

// ===== design/rwlm_ctrl.sv =====
`timescale 1ns / 1ps

module rwlm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rwlm_pkg::rwlm_stat_t stat,
  output rwlm_pkg::rwlm_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import rwlm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_SCAN;
      S_SCAN:  if (stat.scan_done) state_next = S_EVAL;
      S_EVAL:  state_next = stat.need_shift ? S_SHIFT : S_RESP;
      S_SHIFT: if (stat.shift_done) state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath commands
  always_comb begin
    cmd.load  = (state == S_IDLE) && start;
    cmd.scan  = (state == S_SCAN);
    cmd.eval  = (state == S_EVAL);
    cmd.shift = (state == S_SHIFT);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

// ===== design/rwlm_dpath.sv =====
`timescale 1ns / 1ps

module rwlm_dpath (
  input  logic                clk,
  input  logic                rst,
  input  rwlm_pkg::rwlm_cmd_t cmd,
  input  logic [1:0]          req_type,
  input  logic [7:0]          requester_id,
  output rwlm_pkg::rwlm_stat_t stat,
  output logic [3:0]          status,
  output logic [3:0]          reader_count,
  output logic                writer_active
);
  import rwlm_pkg::*;

  // reader id table, compacted into entries below count
  id_t        table_ids [MAX_READERS];

  logic [1:0] kind;
  id_t        id;
  cnt_t       count;
  logic       writer_busy;
  id_t        writer_owner;
  cnt_t       idx;
  logic       found;
  logic [IDX_W-1:0] pos;
  logic [3:0] status_reg;

  cnt_t       pos_ext;
  cnt_t       pos_inc;
  logic [IDX_W-1:0] rd_addr;
  id_t        rd_data;
  logic       in_range;
  logic       hit;

  assign pos_ext  = cnt_t'(pos);
  assign pos_inc  = pos_ext + cnt_t'(1);
  assign in_range = (idx < count);
  assign rd_addr  = cmd.shift ? pos_inc[IDX_W-1:0] : idx[IDX_W-1:0];
  assign rd_data  = table_ids[rd_addr];
  assign hit      = in_range && (rd_data == id);

  // status towards the controller
  always_comb begin
    stat.scan_done  = hit || !in_range;
    stat.need_shift = (kind == REQ_STOP_READ) && (count != '0) && found;
    stat.shift_done = (pos_inc >= count);
  end

  // request latch, scan and compaction pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= req_type;
      id    <= to_id(requester_id);
      idx   <= '0;
      found <= 1'b0;
      pos   <= '0;
    end else if (cmd.scan) begin
      if (hit) begin
        found <= 1'b1;
        pos   <= idx[IDX_W-1:0];
      end else if (in_range) begin
        idx <= idx + cnt_t'(1);
      end
    end else if (cmd.shift && !stat.shift_done) begin
      pos <= pos_inc[IDX_W-1:0];
    end
  end

  // table writes: append on grant, move down on compaction
  always_ff @(posedge clk) begin
    if (cmd.eval && kind == REQ_START_READ && !writer_busy && !found &&
        count < cnt_t'(MAX_READERS)) begin
      table_ids[count[IDX_W-1:0]] <= id;
    end else if (cmd.shift && !stat.shift_done) begin
      table_ids[pos] <= rd_data;
    end
  end

  // lock state and decision
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      writer_busy  <= 1'b0;
      writer_owner <= '0;
      status_reg   <= ST_READ_GRANTED;
    end else if (cmd.eval) begin
      case (kind)
        REQ_START_READ: begin
          if (writer_busy) begin
            status_reg <= ST_WRITER_ACTIVE;
          end else if (found) begin
            status_reg <= ST_ALREADY_READ;
          end else if (count >= cnt_t'(MAX_READERS)) begin
            status_reg <= ST_TABLE_FULL;
          end else begin
            count      <= count + cnt_t'(1);
            status_reg <= ST_READ_GRANTED;
          end
        end
        REQ_STOP_READ: begin
          if (count == '0) begin
            status_reg <= ST_NO_READERS;
          end else if (!found) begin
            status_reg <= ST_NOT_READING;
          end else begin
            status_reg <= ST_READ_STOPPED;
          end
        end
        REQ_START_WRITE: begin
          if (writer_busy) begin
            status_reg <= ST_WRITER_BUSY;
          end else if (count != '0) begin
            status_reg <= ST_READERS_ACTIVE;
          end else begin
            writer_busy  <= 1'b1;
            writer_owner <= id;
            status_reg   <= ST_WRITE_GRANTED;
          end
        end
        REQ_STOP_WRITE: begin
          if (writer_busy && writer_owner == id) begin
            writer_busy <= 1'b0;
            status_reg  <= ST_WRITE_STOPPED;
          end else begin
            status_reg <= ST_NOT_OWNER;
          end
        end
        default: begin
          status_reg <= ST_NOT_OWNER;
        end
      endcase
    end else if (cmd.shift && stat.shift_done) begin
      count <= count - cnt_t'(1);
    end
  end

  assign status        = status_reg;
  assign reader_count  = cnt_to_out(count);
  assign writer_active = writer_busy;

endmodule

// ===== design/readers_writer_lock_manager.sv =====
`timescale 1ns / 1ps

// Readers-writer lock manager. A request (req_type, requester_id) is taken
// when start is high and busy is low; exactly one result beat follows, shown
// on status, reader_count and writer_active for a single cycle while done is
// high, and the receiver cannot stall it. Each request first scans the reader
// id table for the id through its single read port, passing over every active
// entry when there is no match and those ahead of the match otherwise; a stop
// read that succeeds then compacts the table, moving each active entry from
// the match onwards down by one. busy stays high from acceptance until the
// result cycle ends, and the next request can be taken at the end of the
// cycle after the result.
module readers_writer_lock_manager (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [7:0] requester_id,
  output logic       busy,
  output logic       done,
  output logic [3:0] status,
  output logic [3:0] reader_count,
  output logic       writer_active
);
  import rwlm_pkg::*;

  rwlm_cmd_t  cmd;
  rwlm_stat_t stat;

  // sequencer
  rwlm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // table and lock state
  rwlm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .requester_id  (requester_id),
    .stat          (stat),
    .status        (status),
    .reader_count  (reader_count),
    .writer_active (writer_active)
  );

endmodule
